// ===== rtl/core/msa_pkg.sv =====
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants and types for the median-of-two-sorted-arrays block.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int MAX_LENGTH = 1024;                  // entries per store
  localparam int ADDR_W     = $clog2(MAX_LENGTH);    // store address width
  localparam int LEN_W      = 11;                    // array_length register width
  localparam int N_W        = ADDR_W + 1;            // effective length, holds MAX_LENGTH
  localparam int CNT_W      = ADDR_W + 2;            // load counter, holds 2 * MAX_LENGTH
  localparam int CMP_W      = (LEN_W > N_W) ? LEN_W : N_W;
  localparam int DATA_W     = 32;

  localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(2);

  typedef enum logic [2:0] {
    ST_LOAD,    // taking array elements
    ST_ISSUE,   // window check, issue store reads
    ST_CMP,     // compare middle elements, halve windows
    ST_ENDS_L,  // left ends read back, right ends issued
    ST_ENDS_R,  // right ends read back
    ST_SINGLE,  // length one: min and max of the two values
    ST_OUT      // hand result to the output register
  } msa_state_t;

endpackage

// ===== rtl/core/median_of_two_sorted_arrays.sv =====
// ----------------------------------------------------------------------------
// median_of_two_sorted_arrays
// Loads two sorted arrays of equal length and returns the two middle values
// of their merge by a binary search over both arrays.
// ----------------------------------------------------------------------------
// Loading: one element per cycle while in ST_LOAD, 2*n transactions per result (n = length).
// Search: each halving step passes through ST_ISSUE then ST_CMP; the end reads use
//   ST_ENDS_L and ST_ENDS_R, the result hand-off ST_OUT; length one uses ST_SINGLE. Both
//   stores have a single read port each, which splits a step into issue and compare.
// Input is stalled from the last element until the result enters the output
//   register. rst (synchronous) clears control state; array_length returns to 2.
module median_of_two_sorted_arrays (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [msa_pkg::LEN_W-1:0]           cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [msa_pkg::DATA_W-1:0]   value,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [msa_pkg::DATA_W-1:0]   lower_median,
  output logic signed [msa_pkg::DATA_W-1:0]   upper_median
);

  import msa_pkg::*;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  msa_state_t        state, state_next;
  logic [LEN_W-1:0]  array_length;
  logic [CNT_W-1:0]  load_count, load_count_next;
  logic [ADDR_W-1:0] a_left, a_left_next, a_right, a_right_next;
  logic [ADDR_W-1:0] b_left, b_left_next, b_right, b_right_next;
  logic [ADDR_W-1:0] a_mid, a_mid_next, b_mid, b_mid_next;
  logic signed [DATA_W-1:0] lo_res, lo_res_next, hi_res, hi_res_next;

  // --------------------------------------------------------------------------
  // Effective length: zero counts as one, saturate at the store depth
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] len_ext;
  logic [N_W-1:0]   n_eff;
  logic             single;

  always_comb begin
    len_ext = CMP_W'(array_length);
    if (len_ext == '0) begin
      n_eff = N_W'(1);
    end else if (len_ext > CMP_W'(MAX_LENGTH)) begin
      n_eff = N_W'(MAX_LENGTH);
    end else begin
      n_eff = len_ext[N_W-1:0];
    end
  end

  assign single = (n_eff == N_W'(1));

  // --------------------------------------------------------------------------
  // Element stores
  // --------------------------------------------------------------------------
  logic              in_accept;
  logic              out_free;
  logic              in_first;
  logic [CNT_W-1:0]  n_cnt;
  logic [CNT_W-1:0]  b_offset;
  logic [ADDR_W-1:0] wr_addr;
  logic              last_elem;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0] rd_data_a, rd_data_b;
  logic signed [DATA_W-1:0] da, db;
  logic              a_lt_b;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign n_cnt     = CNT_W'(n_eff);
  assign in_first  = (load_count < n_cnt);
  assign b_offset  = load_count - n_cnt;
  assign wr_addr   = in_first ? load_count[ADDR_W-1:0] : b_offset[ADDR_W-1:0];
  assign last_elem = ((load_count + CNT_W'(1)) == {n_cnt[CNT_W-2:0], 1'b0});
  assign da        = $signed(rd_data_a);
  assign db        = $signed(rd_data_b);

  // the one shared signed compare; on a tie both operands are the same value
  assign a_lt_b    = (da < db);

  msa_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_store_a (
    .clk     (clk),
    .wr_en   (in_accept && in_first),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  msa_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_store_b (
    .clk     (clk),
    .wr_en   (in_accept && !in_first),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  // --------------------------------------------------------------------------
  // Window arithmetic: midpoints and parity of each window
  // --------------------------------------------------------------------------
  logic [ADDR_W:0]   a_sum, b_sum;
  logic [ADDR_W-1:0] a_mid_c, b_mid_c;
  logic              win_done;

  assign a_sum    = {1'b0, a_left} + {1'b0, a_right};
  assign b_sum    = {1'b0, b_left} + {1'b0, b_right};
  assign a_mid_c  = a_sum[ADDR_W:1];
  assign b_mid_c  = b_sum[ADDR_W:1];
  assign win_done = ((a_right - a_left) == ADDR_W'(1)) &&
                    ((b_right - b_left) == ADDR_W'(1));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    a_left_next     = a_left;
    a_right_next    = a_right;
    b_left_next     = b_left;
    b_right_next    = b_right;
    a_mid_next      = a_mid;
    b_mid_next      = b_mid;
    lo_res_next     = lo_res;
    hi_res_next     = hi_res;
    rd_addr_a       = a_mid;
    rd_addr_b       = b_mid;
    in_stall        = 1'b1;

    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_accept) begin
          if (last_elem) begin
            load_count_next = '0;
            a_left_next     = '0;
            b_left_next     = '0;
            a_right_next    = ADDR_W'(n_eff - N_W'(1));
            b_right_next    = ADDR_W'(n_eff - N_W'(1));
            state_next      = ST_ISSUE;
          end else begin
            load_count_next = load_count + CNT_W'(1);
          end
        end
      end

      ST_ISSUE: begin
        if (single) begin
          // both windows sit at entry 0
          rd_addr_a  = '0;
          rd_addr_b  = '0;
          state_next = ST_SINGLE;
        end else if (win_done) begin
          rd_addr_a  = a_left;
          rd_addr_b  = b_left;
          state_next = ST_ENDS_L;
        end else begin
          rd_addr_a  = a_mid_c;
          rd_addr_b  = b_mid_c;
          a_mid_next = a_mid_c;
          b_mid_next = b_mid_c;
          state_next = ST_CMP;
        end
      end

      ST_CMP: begin
        // ties take the B-not-greater branch
        if (a_lt_b) begin
          a_left_next  = a_mid;
          b_right_next = b_sum[0] ? b_mid + ADDR_W'(1) : b_mid;
        end else begin
          b_left_next  = b_mid;
          a_right_next = a_sum[0] ? a_mid + ADDR_W'(1) : a_mid;
        end
        state_next = ST_ISSUE;
      end

      ST_ENDS_L: begin
        lo_res_next = a_lt_b ? db : da;
        rd_addr_a   = a_right;
        rd_addr_b   = b_right;
        state_next  = ST_ENDS_R;
      end

      ST_ENDS_R: begin
        hi_res_next = a_lt_b ? da : db;
        state_next  = ST_OUT;
      end

      ST_SINGLE: begin
        lo_res_next = a_lt_b ? da : db;
        hi_res_next = a_lt_b ? db : da;
        state_next  = ST_OUT;
      end

      ST_OUT: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase

    // a length write restarts loading
    if (cfg_write) begin
      load_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      load_count   <= '0;
      array_length <= LENGTH_RESET;
      a_left       <= '0;
      a_right      <= '0;
      b_left       <= '0;
      b_right      <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      a_left     <= a_left_next;
      a_right    <= a_right_next;
      b_left     <= b_left_next;
      b_right    <= b_right_next;
      if (cfg_write) begin
        array_length <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_mid  <= a_mid_next;
    b_mid  <= b_mid_next;
    lo_res <= lo_res_next;
    hi_res <= hi_res_next;
  end

  // --------------------------------------------------------------------------
  // Output register: frees the search from the downstream stall
  // --------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state == ST_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      lower_median <= lo_res;
      upper_median <= hi_res;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_win_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE && !single) |-> (a_right > a_left) && (b_right > b_left))
    else $error("search window collapsed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (load_count < {n_cnt[CNT_W-2:0], 1'b0}))
    else $error("load count beyond both arrays");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == ST_LOAD))
    else $error("result not presented after search");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> in_stall)
    else $error("input taken during search");

endmodule

// ===== rtl/core/msa_ram.sv =====
// ----------------------------------------------------------------------------
// msa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msa_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for median_of_two_sorted_arrays. A short directed
// table is followed by random array pairs under four pacing schemes; every output
// transaction is checked against a behavioural model held in the bench or a typed row.
// ----------------------------------------------------------------------------
module testbench;

  import msa_pkg::*;

  // Cycles to let the search finish after the last output, before a length
  // write lands on a load that is still open.
  localparam int SEARCH_SETTLE   = 40;
  localparam int WATCHDOG_LIMIT  = 2000;   // cycles with no transaction at all
  localparam int RANDOM_ITEMS    = 800;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } medians_t;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic signed [DATA_W-1:0] data;     // element, or length for ROW_CFG
    logic                     typed;    // expected result given in the row
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } stim_row_t;

  typedef enum logic [1:0] {
    PACE_FULL,          // no gaps, no stalls
    PACE_SEND_GAPS,     // sender idle 47 %
    PACE_RECV_STALLS,   // receiver stalls 47 %
    PACE_BOTH           // both at 9 %
  } pace_t;

  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [LEN_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] lower_median;
  logic signed [DATA_W-1:0] upper_median;

  median_of_two_sorted_arrays uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .lower_median (lower_median),
    .upper_median (upper_median)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model state: length register, both stores and the load counter
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]         model_length;
  int unsigned              model_loaded;
  logic signed [DATA_W-1:0] model_a [MAX_LENGTH];
  logic signed [DATA_W-1:0] model_b [MAX_LENGTH];

  medians_t    pending_medians [$];   // results still owed by the DUT
  int unsigned fail_count     = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // pacing, in per cent
  int unsigned send_gap_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // typed expectation for the directed row now on the input
  logic     row_typed = 1'b0;
  medians_t row_expected;

  // zero reads as one, anything beyond the stores saturates
  function automatic int unsigned effective_len(input logic [LEN_W-1:0] len);
    if (len == 0)
      return 1;
    if (len > MAX_LENGTH)
      return MAX_LENGTH;
    return 32'(len);
  endfunction

  // Windowed halving search over both stores; stops once each window is a pair.
  function automatic medians_t search_medians(input int unsigned n);
    int unsigned a_l, a_r, b_l, b_r, a_m, b_m;
    medians_t    m;
    a_l = 0; a_r = n - 1;
    b_l = 0; b_r = n - 1;
    while (!((a_r - a_l == 1) && (b_r - b_l == 1))) begin
      a_m = (a_l + a_r) / 2;
      b_m = (b_l + b_r) / 2;
      if (model_a[a_m] < model_b[b_m]) begin
        a_l = a_m;
        b_r = ((b_l + b_r + 1) % 2 == 0) ? b_m + 1 : b_m;
      end else begin
        // ties land here
        b_l = b_m;
        a_r = ((a_l + a_r + 1) % 2 == 0) ? a_m + 1 : a_m;
      end
    end
    m.lo = (model_a[a_l] >= model_b[b_l]) ? model_a[a_l] : model_b[b_l];
    m.hi = (model_a[a_r] <= model_b[b_r]) ? model_a[a_r] : model_b[b_r];
    return m;
  endfunction

  // Store one accepted element; a result falls out on the last element of B.
  task automatic absorb_element(input logic signed [DATA_W-1:0] v,
                                output bit done, output medians_t m);
    int unsigned n;
    n    = effective_len(model_length);
    done = 1'b0;
    m    = '0;
    if (model_loaded >= 2 * n)
      model_loaded = 0;
    if (model_loaded < n)
      model_a[model_loaded] = v;
    else
      model_b[model_loaded - n] = v;
    model_loaded++;
    if (model_loaded >= 2 * n) begin
      model_loaded = 0;
      done = 1'b1;
      if (n == 1) begin
        m.lo = (model_a[0] <= model_b[0]) ? model_a[0] : model_b[0];
        m.hi = (model_a[0] <= model_b[0]) ? model_b[0] : model_a[0];
      end else begin
        m = search_medians(n);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit       got;
    medians_t calc;
    medians_t want;
    if (rst) begin
      model_length = LENGTH_RESET;
      model_loaded = 0;
      pending_medians.delete();
    end else begin
      if (cfg_write) begin
        model_length = cfg_data;
        model_loaded = 0;       // a write reopens the load
      end
      if (in_valid && !in_stall) begin
        absorb_element(value, got, calc);
        if (got)
          pending_medians.push_back(row_typed ? row_expected : calc);
      end
      if (out_valid && !out_stall) begin
        if (pending_medians.size() == 0) begin
          fail_count++;
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: unexpected result lo=%0d hi=%0d", $time,
                     lower_median, upper_median);
          mismatch_count++;
        end else begin
          want = pending_medians.pop_front();
          if (lower_median !== want.lo || upper_median !== want.hi) begin
            fail_count++;
            if (mismatch_count < REPORT_LIMIT)
              $display("%0t: mismatch lo exp %0d got %0d, hi exp %0d got %0d",
                       $time, want.lo, lower_median, want.hi, upper_median);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction of any kind happens.
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stall decided afresh at every falling edge.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // --------------------------------------------------------------------------
  // Driver tasks (all entered and left at a falling edge)
  // --------------------------------------------------------------------------
  task automatic set_pace(input pace_t p);
    case (p)
      PACE_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      PACE_SEND_GAPS:   begin send_gap_pct = 47; recv_stall_pct = 0;  end
      PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 47; end
      default:          begin send_gap_pct = 9;  recv_stall_pct = 9;  end
    endcase
  endtask

  // Valid is left high on return so back-to-back transactions stay gapless.
  task automatic send_value(input logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Nothing owed and the search given time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_medians.size() != 0)
      @(negedge clk);
    repeat (SEARCH_SETTLE) @(negedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_write <= 1'b1;
    cfg_data  <= len;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One array of n elements; mostly ascending, sometimes left in random order.
  task automatic send_array(input int unsigned n);
    logic signed [DATA_W-1:0] elems [MAX_LENGTH];
    logic signed [DATA_W-1:0] tmp;
    int                       style;
    int                       j;
    bit                       ascending;
    style     = $urandom_range(2);
    ascending = ($urandom_range(99) < 85);
    for (int i = 0; i < n; i++) begin
      case (style)
        0:       elems[i] = $urandom();
        1:       elems[i] = 32'(int'($urandom_range(16)) - 8);   // many ties
        default: begin
          case ($urandom_range(3))
            0:       elems[i] = S_MIN;
            1:       elems[i] = S_MAX;
            2:       elems[i] = -1;
            default: elems[i] = 0;
          endcase
        end
      endcase
    end
    if (ascending) begin
      for (int i = 1; i < n; i++) begin
        tmp = elems[i];
        j   = i - 1;
        while (j >= 0 && elems[j] > tmp) begin
          elems[j + 1] = elems[j];
          j--;
        end
        elems[j + 1] = tmp;
      end
    end
    for (int i = 0; i < n; i++)
      send_value(elems[i]);
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Typed results only where obvious; the rest go to the model.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [29] = '{
    // reset length 2: lo = max of left ends, hi = min of right ends
    '{ROW_ITEM, S_MIN, 1'b0, 32'sd0,  32'sd0},
    '{ROW_ITEM, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, -32'sd5, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, S_MAX, 1'b1, -32'sd5, 32'sd0},
    // half-loaded pair, then a length write must throw it away
    '{ROW_ITEM, 32'sd9, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  32'sd1, 1'b0, 32'sd0, 32'sd0},
    // length one: min and max
    '{ROW_ITEM, 32'sd7, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, -32'sd3, 1'b1, -32'sd3, 32'sd7},
    '{ROW_ITEM, 32'sd5, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd5, 1'b1, 32'sd5, 32'sd5},
    // length zero behaves as one
    '{ROW_CFG,  32'sd0, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, S_MAX, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, S_MIN, 1'b1, S_MIN, S_MAX},
    // odd length, model checked
    '{ROW_CFG,  32'sd3, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd1, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd3, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd4, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd5, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd6, 1'b0, 32'sd0, 32'sd0},
    // all ties: every compare takes the not-greater branch
    '{ROW_CFG,  32'sd4, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b0, 32'sd0, 32'sd0},
    '{ROW_ITEM, 32'sd2, 1'b1, 32'sd2, 32'sd2}
  };

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    int unsigned      random_items;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      pairs;
    int unsigned      pick;
    logic [LEN_W-1:0] len;

    random_items = 0;
    phase        = 0;
    set_pace(PACE_FULL);

    // reset released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_length(directed_rows[r].data[LEN_W-1:0]);
      end else begin
        row_typed       = directed_rows[r].typed;
        row_expected.lo = directed_rows[r].lo;
        row_expected.hi = directed_rows[r].hi;
        send_value(directed_rows[r].data);
        row_typed       = 1'b0;
      end
    end

    // Random phases: short lengths, several pairs each, pacing rotated.
    while (random_items < RANDOM_ITEMS) begin
      set_pace(pace_t'(phase % 4));
      pick = $urandom_range(99);
      if (pick < 6)
        len = '0;
      else if (pick < 12)
        len = LEN_W'(1);
      else if (pick < 20)
        len = LEN_W'(2);
      else
        len = LEN_W'($urandom_range(16, 3));
      n = effective_len(len);
      wait_idle();
      write_length(len);
      pairs = $urandom_range(5, 2);
      repeat (pairs) begin
        send_array(n);
        send_array(n);
      end
      random_items += pairs * 2 * n;
      // now and then leave a load half done; the next write discards it
      if ($urandom_range(99) < 25) begin
        pick = $urandom_range(2 * n - 1, 1);
        repeat (pick) send_value($urandom());
        random_items += pick;
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && pending_medians.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/msa_pkg.sv
rtl/core/msa_ram.sv
rtl/core/median_of_two_sorted_arrays.sv
verif/testbench.sv
